@@ design/gtr_pkg.sv @@
// ----------------------------------------------------------------------------
// gtr_pkg
// shared widths, constants and types of the gelu tanh rational unit
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int IFRAC      = 24;

  localparam int AW    = IFRAC + 3;
  localparam int X2W   = IFRAC + 5;
  localparam int X3W   = IFRAC + 7;
  localparam int VW    = IFRAC + 3;
  localparam int UW    = IFRAC + 2;
  localparam int U2W   = IFRAC + 4;
  localparam int NUMW  = IFRAC + 6;
  localparam int DENW  = IFRAC + 7;
  localparam int PRODW = UW + NUMW;
  localparam int QW    = IFRAC + 1;
  localparam int FW    = IFRAC + 2;
  localparam int P2W   = DATA_WIDTH + FW + 1;
  localparam int MW    = P2W - (IFRAC + 1);

  localparam logic [QW-1:0]   ONE_I  = QW'(1) << IFRAC;
  localparam logic [QW-1:0]   HALF_I = QW'(1) << (IFRAC - 1);
  localparam logic [23:0]     C1_Q   = 24'd13386282;
  localparam logic [19:0]     C2_Q   = 20'd750193;
  localparam logic [UW-1:0]   U_MAX  = UW'(3) << IFRAC;
  localparam logic [DENW-1:0] K27    = DENW'(27) << IFRAC;
  localparam logic [DATA_WIDTH-1:0] X_MAX = DATA_WIDTH'(4) << FRAC_BITS;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] mag;
    logic                  neg;
    logic                  last;
  } gtr_side_t;

endpackage

@@ design/gelu_tanh_rational_unit_core.sv @@
// ----------------------------------------------------------------------------
// gelu_tanh_rational_unit_core
// gelu of a signed q4.12 activation, tanh by a clamped rational form
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       request    in_valid_i / in_stall_o   x_in_i, in_last_i
//  out      result     out_valid_o / out_stall_i y_out_o, out_last_o
//
//  one request enters per cycle while in_stall_o is low; the pipeline is seven front
//  stages, the divider (one setup stage plus one stage per quotient bit, 25
//  bits) and two back stages.
//  reset clears all stage valid bits; the pipeline then accepts at once.
//  a stall holds only the stages that are full up to the first empty one,
//  so bubbles close up while the output waits.
// ----------------------------------------------------------------------------
module gelu_tanh_rational_unit_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [gtr_pkg::DATA_WIDTH-1:0] x_in_i,
  input  logic                             in_last_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [gtr_pkg::DATA_WIDTH-1:0] y_out_o,
  output logic                             out_last_o
);
  import gtr_pkg::*;

  function automatic logic [39:0] rmul(input logic [31:0] p, input logic [31:0] q);
    logic [63:0] full;
    full = 64'(p) * 64'(q) + 64'(HALF_I);
    return full[63:IFRAC];
  endfunction

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v9_q, v10_q;
  logic en1, en2, en3, en4, en5, en6, en7, en9, en10;
  logic div_stall, div_valid;

  gtr_side_t s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q, s9_q;
  gtr_side_t side_in, div_side;

  logic [AW-1:0]    a1_q, a2_q, a3_q;
  logic [X2W-1:0]   x2_q;
  logic [X3W-1:0]   x3_q;
  logic [VW-1:0]    v4v_q;
  logic [UW-1:0]    u5_q, u6_q;
  logic [U2W-1:0]   u2_q;
  logic [PRODW-1:0] prod_q;
  logic [DENW-1:0]  den_q;
  logic [P2W-1:0]   prod2_q;
  logic [DATA_WIDTH-1:0] y_q;
  logic             last10_q, neg10_q;

  logic [DATA_WIDTH-1:0] raw_mag, clamp_mag;
  logic [AW-1:0]    a_d;
  logic [VW-1:0]    v_d;
  logic [VW-1:0]    u_full;
  logic [UW-1:0]    u_d;
  logic [NUMW-1:0]  num_d;
  logic [DENW-1:0]  den_d;
  logic [QW-1:0]    quot;
  logic [FW-1:0]    f_d;
  logic [MW-1:0]    m_raw, m_sat;
  logic [DATA_WIDTH-1:0] y_d;

  assign en10 = ~v10_q | ~out_stall_i;
  assign en9  = ~v9_q | en10;
  assign en7  = ~v7_q | ~div_stall;
  assign en6  = ~v6_q | en7;
  assign en5  = ~v5_q | en6;
  assign en4  = ~v4_q | en5;
  assign en3  = ~v3_q | en4;
  assign en2  = ~v2_q | en3;
  assign en1  = ~v1_q | en2;
  assign in_stall_o = ~en1;

  // magnitude and clamp of the tanh argument
  always_comb begin
    raw_mag = x_in_i[DATA_WIDTH-1] ? DATA_WIDTH'(-x_in_i) : DATA_WIDTH'(x_in_i);
    clamp_mag = (raw_mag > X_MAX) ? X_MAX : raw_mag;
    a_d = AW'(clamp_mag) << (IFRAC - FRAC_BITS);
    side_in.mag  = raw_mag;
    side_in.neg  = x_in_i[DATA_WIDTH-1];
    side_in.last = in_last_i;
  end

  always_comb begin
    v_d    = a3_q + VW'(rmul(32'(C2_Q), 32'(x3_q)));
    u_full = VW'(rmul(32'(C1_Q), 32'(v4v_q)));
    u_d    = (u_full > VW'(U_MAX)) ? U_MAX : UW'(u_full);
    num_d  = NUMW'(K27) + NUMW'(u2_q);
    den_d  = K27 + (DENW'(u2_q) << 3) + DENW'(u2_q);
    f_d    = div_side.neg ? (FW'(ONE_I) - FW'(quot)) : (FW'(ONE_I) + FW'(quot));
    m_raw  = prod2_q[P2W-1:IFRAC+1];
    if (s9_q.neg) begin
      m_sat = (m_raw > (MW'(1) << (DATA_WIDTH - 1))) ? (MW'(1) << (DATA_WIDTH - 1)) : m_raw;
      y_d   = DATA_WIDTH'(MW'(0) - m_sat);
    end else begin
      m_sat = (m_raw > ((MW'(1) << (DATA_WIDTH - 1)) - MW'(1)))
              ? ((MW'(1) << (DATA_WIDTH - 1)) - MW'(1)) : m_raw;
      y_d   = DATA_WIDTH'(m_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      if (en1)  v1_q  <= in_valid_i;
      if (en2)  v2_q  <= v1_q;
      if (en3)  v3_q  <= v2_q;
      if (en4)  v4_q  <= v3_q;
      if (en5)  v5_q  <= v4_q;
      if (en6)  v6_q  <= v5_q;
      if (en7)  v7_q  <= v6_q;
      if (en9)  v9_q  <= div_valid;
      if (en10) v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      a1_q <= a_d;
      s1_q <= side_in;
    end
    if (en2 && v1_q) begin
      x2_q <= X2W'(rmul(32'(a1_q), 32'(a1_q)));
      a2_q <= a1_q;
      s2_q <= s1_q;
    end
    if (en3 && v2_q) begin
      x3_q <= X3W'(rmul(32'(x2_q), 32'(a2_q)));
      a3_q <= a2_q;
      s3_q <= s2_q;
    end
    if (en4 && v3_q) begin
      v4v_q <= v_d;
      s4_q  <= s3_q;
    end
    if (en5 && v4_q) begin
      u5_q <= u_d;
      s5_q <= s4_q;
    end
    if (en6 && v5_q) begin
      u2_q <= U2W'(rmul(32'(u5_q), 32'(u5_q)));
      u6_q <= u5_q;
      s6_q <= s5_q;
    end
    if (en7 && v6_q) begin
      prod_q <= PRODW'(u6_q) * PRODW'(num_d);
      den_q  <= den_d;
      s7_q   <= s6_q;
    end
    if (en9 && div_valid) begin
      prod2_q <= P2W'(div_side.mag) * P2W'(f_d) + P2W'(ONE_I);
      s9_q    <= div_side;
    end
    if (en10 && v9_q) begin
      y_q      <= y_d;
      last10_q <= s9_q.last;
      neg10_q  <= s9_q.neg;
    end
  end

  gtr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v7_q),
    .in_stall_o  (div_stall),
    .dividend_i  (prod_q),
    .den_i       (den_q),
    .side_i      (s7_q),
    .out_valid_o (div_valid),
    .out_stall_i (~en9),
    .quot_o      (quot),
    .side_o      (div_side)
  );

  assign out_valid_o = v10_q;
  assign y_out_o     = y_q;
  assign out_last_o  = last10_q;

  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !neg10_q |-> !y_out_o[DATA_WIDTH-1])
    else $error("positive input gave negative result");

  a_u_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> u5_q <= U_MAX)
    else $error("tanh argument above clamp");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("stall raised with empty output stage");

endmodule

@@ design/gtr_div.sv @@
// ----------------------------------------------------------------------------
// gtr_div
// pipelined restoring divider, one quotient bit per stage, rounded quotient
// ----------------------------------------------------------------------------
module gtr_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [gtr_pkg::PRODW-1:0] dividend_i,
  input  logic [gtr_pkg::DENW-1:0]  den_i,
  input  gtr_pkg::gtr_side_t      side_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [gtr_pkg::QW-1:0]  quot_o,
  output gtr_pkg::gtr_side_t      side_o
);
  import gtr_pkg::*;

  logic [QW:0]     v_q;
  logic [QW+1:0]   en;
  logic [DENW-1:0] rem_q  [QW+1];
  logic [DENW-1:0] den_q  [QW+1];
  logic [QW-1:0]   low_q  [QW+1];
  logic [QW-1:0]   quo_q  [QW+1];
  gtr_side_t       side_q [QW+1];
  logic [PRODW:0]  n_sum;

  assign en[QW+1] = ~out_stall_i;
  assign in_stall_o = ~en[0];
  assign n_sum = {1'b0, dividend_i} + (PRODW + 1)'(den_i >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      rem_q[0]  <= n_sum[QW+DENW-1:QW];
      low_q[0]  <= n_sum[QW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k <= QW; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DENW:0]   shifted;
    logic [DENW+1:0] diff;
    logic            qbit;

    assign shifted = {rem_q[k-1], low_q[k-1][QW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_q[k-1]};
    assign qbit    = ~diff[DENW+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && v_q[k-1]) begin
        rem_q[k]  <= qbit ? diff[DENW-1:0] : shifted[DENW-1:0];
        low_q[k]  <= low_q[k-1] << 1;
        quo_q[k]  <= {quo_q[k-1][QW-2:0], qbit};
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid_o = v_q[QW];
  assign quot_o      = quo_q[QW];
  assign side_o      = side_q[QW];

  a_rem_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> rem_q[0] < den_q[0])
    else $error("initial partial remainder not below divisor");

  a_rem_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QW] |-> rem_q[QW] < den_q[QW])
    else $error("final remainder not below divisor");

  a_quot_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quot_o <= ONE_I)
    else $error("tanh magnitude above one");

endmodule
